### hw/rtl/sha3_pkg.sv
// Shared types, constants and Keccak-f[1600] round functions for the SHA3-256 hash block.
// No dependencies; imported by sha3_ctrl, sha3_dp and sha3_256_hash.
`timescale 1ns / 1ps

package sha3_pkg;

  localparam int LANES          = 25;
  localparam int ROUND_COUNT    = 24;
  localparam int ROUND_W        = $clog2(ROUND_COUNT);
  localparam int DIGEST_BYTES   = 32;
  localparam int DIGEST_WORDS   = DIGEST_BYTES / 8;
  localparam int WORD_IDX_W     = $clog2(DIGEST_WORDS);
  localparam int RATE_BYTES_DEF = 136;
  localparam int POS_W          = 8;

  localparam logic [7:0] LFSR_POLY = 8'h71;
  localparam logic [7:0] LFSR_INIT = 8'h01;
  localparam logic [7:0] PAD_FIRST = 8'h06;
  localparam logic [7:0] PAD_LAST  = 8'h80;

  typedef logic [63:0] lane_t;
  typedef lane_t [LANES-1:0] sponge_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic absorb;
    logic pad;
    logic round;
    logic load;
  } sha3_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_end;
    logic out_busy;
  } sha3_sts_t;

  // Round constant and the LFSR value that the next round starts from.
  typedef struct packed {
    lane_t      rc;
    logic [7:0] lfsr;
  } rc_step_t;

  // Rotation offsets of the rho step, indexed by x + 5*y.
  localparam int RHO [LANES] = '{
     0,  1, 62, 28, 27,
    36, 44,  6, 55, 20,
     3, 10, 43, 25, 39,
    41, 45, 15, 21,  8,
    18,  2, 61, 56, 14
  };

  // Rotate a lane left by a constant amount; a shift by 64 yields zero.
  function automatic lane_t rotl64(lane_t v, int n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // Seven LFSR steps give the iota constant of one round.
  function automatic rc_step_t lfsr_round(logic [7:0] l);
    rc_step_t   o;
    logic [7:0] v;
    v    = l;
    o.rc = '0;
    for (int j = 0; j < 7; j++) begin
      v = {v[6:0], 1'b0} ^ (v[7] ? LFSR_POLY : 8'h00);
      if (v[1]) begin
        o.rc[(1 << j) - 1] = 1'b1;
      end
    end
    o.lfsr = v;
    return o;
  endfunction

  // One full round: theta, rho, pi, chi and iota.
  function automatic sponge_t keccak_round(sponge_t s, lane_t rc);
    lane_t   c [5];
    lane_t   d [5];
    sponge_t a;
    sponge_t b;
    sponge_t r;
    for (int x = 0; x < 5; x++) begin
      c[x] = s[x] ^ s[x+5] ^ s[x+10] ^ s[x+15] ^ s[x+20];
    end
    for (int x = 0; x < 5; x++) begin
      d[x] = c[(x+4)%5] ^ rotl64(c[(x+1)%5], 1);
    end
    for (int x = 0; x < 5; x++) begin
      for (int y = 0; y < 5; y++) begin
        a[x+5*y] = s[x+5*y] ^ d[x];
      end
    end
    for (int x = 0; x < 5; x++) begin
      for (int y = 0; y < 5; y++) begin
        b[y+5*((2*x+3*y)%5)] = rotl64(a[x+5*y], RHO[x+5*y]);
      end
    end
    for (int x = 0; x < 5; x++) begin
      for (int y = 0; y < 5; y++) begin
        r[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
      end
    end
    r[0] = r[0] ^ rc;
    return r;
  endfunction

endpackage

### hw/rtl/sha3_ctrl.sv
// Controller of the SHA3-256 hash block: sequences absorb, padding, rounds and digest unload.
// Depends on sha3_pkg for the command and status types.
`timescale 1ns / 1ps

module sha3_ctrl
  import sha3_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_byte_valid,
  input  logic      in_last,
  output logic      in_stall,
  input  sha3_sts_t sts,
  output sha3_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UNLOAD
  } ctrl_state_t;

  ctrl_state_t          state_r, state_nxt;
  logic [ROUND_W-1:0]   round_r, round_nxt;
  logic                 final_r, final_nxt;
  logic                 pend_last_r, pend_last_nxt;
  logic                 accept;

  // Words are taken only while no padding, permutation or unload is in progress.
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Commands decoded from the current state, the input handshake and the datapath status.
  assign cmd.absorb = accept && in_byte_valid;
  assign cmd.pad    = (state_r == ST_PAD);
  assign cmd.round  = (state_r == ST_ROUND);
  assign cmd.load   = (state_r == ST_UNLOAD) && !sts.out_busy;

  // Next-state logic.
  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    final_nxt     = final_r;
    pend_last_nxt = pend_last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_byte_valid && sts.pos_end) begin
            // The byte fills the block: permute, then pad if the message ends here.
            state_nxt     = ST_ROUND;
            final_nxt     = 1'b0;
            pend_last_nxt = in_last;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        state_nxt     = ST_ROUND;
        final_nxt     = 1'b1;
        pend_last_nxt = 1'b0;
      end
      ST_ROUND: begin
        round_nxt = round_r + 1'b1;
        if (round_r == ROUND_W'(ROUND_COUNT - 1)) begin
          round_nxt = '0;
          if (final_r) begin
            state_nxt = ST_UNLOAD;
          end else if (pend_last_r) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_UNLOAD: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      final_r     <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      final_r     <= final_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

endmodule

### hw/rtl/sha3_dp.sv
// Datapath of the SHA3-256 hash block: sponge state, byte absorb, round unit and digest buffer.
// Depends on sha3_pkg for the round functions and the command and status types.
`timescale 1ns / 1ps

module sha3_dp
  import sha3_pkg::*;
#(
  parameter int RATE_BYTES = RATE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha3_cmd_t             cmd,
  output sha3_sts_t             sts,
  input  logic [7:0]            in_data_byte,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [63:0]           out_digest_word,
  output logic [WORD_IDX_W-1:0] out_word_index,
  output logic                  out_last_word
);

  localparam int PAD_LANE = (RATE_BYTES - 1) / 8;
  localparam int PAD_SH   = ((RATE_BYTES - 1) % 8) * 8;

  sponge_t               sponge_r, sponge_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [7:0]            lfsr_r, lfsr_nxt;
  rc_step_t              step;
  lane_t                 byte_word;
  logic [4:0]            pos_lane;
  logic                  pos_end;
  lane_t                 digest_r [DIGEST_WORDS];
  logic                  busy_r;
  logic [WORD_IDX_W-1:0] idx_r;
  logic                  out_take;

  assign pos_lane = pos_r[POS_W-1:3];
  assign pos_end  = (pos_r == POS_W'(RATE_BYTES - 1));
  assign step     = lfsr_round(lfsr_r);

  // The byte to merge, absorbed data or the first padding byte, shifted to its place in the lane.
  assign byte_word = 64'(cmd.pad ? PAD_FIRST : in_data_byte) << {pos_r[2:0], 3'b000};

  // Sponge update: absorb, pad, run a round or clear when the digest is loaded into the buffer.
  always_comb begin
    sponge_nxt = sponge_r;
    pos_nxt    = pos_r;
    lfsr_nxt   = LFSR_INIT;
    if (cmd.absorb || cmd.pad) begin
      for (int i = 0; i < LANES; i++) begin
        if (pos_lane == 5'(i)) begin
          sponge_nxt[i] = sponge_r[i] ^ byte_word;
        end
      end
    end
    if (cmd.absorb) begin
      pos_nxt = pos_end ? '0 : pos_r + 1'b1;
    end
    if (cmd.pad) begin
      sponge_nxt[PAD_LANE] = sponge_nxt[PAD_LANE] ^ (64'(PAD_LAST) << PAD_SH);
    end
    if (cmd.round) begin
      sponge_nxt = keccak_round(sponge_r, step.rc);
      lfsr_nxt   = step.lfsr;
    end
    if (cmd.load) begin
      sponge_nxt = '0;
      pos_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sponge_r <= '0;
      pos_r    <= '0;
      lfsr_r   <= LFSR_INIT;
    end else begin
      sponge_r <= sponge_nxt;
      pos_r    <= pos_nxt;
      lfsr_r   <= lfsr_nxt;
    end
  end

  // Digest buffer: holds the four words so the sponge is free for the next message.
  assign out_take = busy_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (cmd.load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (out_take) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r == WORD_IDX_W'(DIGEST_WORDS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < DIGEST_WORDS; k++) begin
        digest_r[k] <= sponge_r[k];
      end
    end
  end

  assign out_valid       = busy_r;
  assign out_digest_word = digest_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == WORD_IDX_W'(DIGEST_WORDS - 1));

  assign sts.pos_end  = pos_end;
  assign sts.out_busy = busy_r;

endmodule

### hw/rtl/sha3_256_hash.sv
// SHA3-256 over a byte stream: one byte word per cycle while in_stall is low, 24 rounds per full block.
// A byte is absorbed into the sponge; one that fills a block starts the rounds. A last word
// leads to padding, the rounds and an unload (after a first permutation if its byte filled
// the block), then four digest words follow, one per cycle while out_stall is low.
// The round unit and the digest buffer set the rate. Synchronous active-low reset clears the
// sponge, position, LFSR, controller and output buffer.
`timescale 1ns / 1ps

module sha3_256_hash
  import sha3_pkg::*;
#(
  parameter int RATE_BYTES = RATE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_byte_valid,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           out_digest_word,
  output logic [WORD_IDX_W-1:0] out_word_index,
  output logic                  out_last_word
);

  sha3_cmd_t cmd;
  sha3_sts_t sts;

  // Controller.
  sha3_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_byte_valid (in_byte_valid),
    .in_last       (in_last),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  // Datapath.
  sha3_dp #(
    .RATE_BYTES (RATE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_data_byte    (in_data_byte),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // A new digest is never loaded over one that is still being sent.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !sts.out_busy)
    else $error("digest loaded while buffer busy");

  // At most one datapath command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.absorb, cmd.pad, cmd.round, cmd.load}))
    else $error("conflicting datapath commands");

  // Taking the final digest word empties the buffer.
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> !out_valid)
    else $error("digest buffer not drained after final word");

  // A last word always starts padding or a permutation, so the input stalls on the next cycle.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> in_stall)
    else $error("input not stalled after last word");

endmodule
